### hdl/sxru_pkg.sv
// Shared types and constants for the sysex ROM dump unpacker.
package sxru_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W = 12;
    localparam int CNT_W = 16;

    localparam int MAX_MESSAGE_LENGTH_DEF = 4095;

    localparam logic [LEN_W-1:0] MIN_LEN = 12'hFC;
    localparam int DATA_START = 10;
    localparam int GROUP = 5;

    localparam logic [DATA_W-1:0] HDR_BYTE1 = 8'h3E;
    localparam logic [DATA_W-1:0] HDR_BYTE3 = 8'h7F;
    localparam logic [DATA_W-1:0] HDR_DUMP_A = 8'h71;
    localparam logic [DATA_W-1:0] HDR_DUMP_B = 8'h72;
    localparam logic [DATA_W-1:0] HDR_DUMP_C = 8'h73;

    localparam logic KIND_ROM = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [LEN_W-1:0]  message_length;
        logic              first_of_message;
        logic              first_of_dump;
    } t_item;

    typedef struct packed {
        logic              advance;
    } t_in_ctrl;

endpackage

### hdl/sxru_in_stage.sv
// Input register stage: holds one accepted byte until the unpack stage takes it.
module sxru_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sxru_pkg::t_item  i_item,
    input  logic             i_advance,
    output sxru_pkg::t_in_ctrl o_ctrl,
    output sxru_pkg::t_item  o_item
);

    logic            r_valid;
    sxru_pkg::t_item r_item;

    assign o_in_stall = r_valid && !i_advance;
    assign o_ctrl.advance = r_valid && i_advance;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### hdl/sxru_unpack.sv
// Header checks, block counter sequencing, LSB unpacking and result register.
module sxru_unpack #(
    parameter int MAX_MESSAGE_LENGTH = sxru_pkg::MAX_MESSAGE_LENGTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sxru_pkg::t_in_ctrl          i_ctrl,
    input  sxru_pkg::t_item             i_item,
    output logic                        o_free,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sxru_pkg::DATA_W-1:0] o_rom_byte,
    output logic                        o_result_kind
);

    localparam int PW = $clog2(MAX_MESSAGE_LENGTH + 1);
    localparam int CW = ((PW > sxru_pkg::LEN_W) ? PW : sxru_pkg::LEN_W) + 1;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_MESSAGE_LENGTH);

    logic [PW-1:0]                r_pos, n_pos;
    logic [2:0]                   r_off, n_off;
    logic [PW-1:0]                r_start, n_start;
    logic                         r_acc, n_acc;
    logic [sxru_pkg::DATA_W-1:0]  r_cnt_hi, n_cnt_hi;
    logic [sxru_pkg::CNT_W-1:0]   r_expect, n_expect;
    logic [sxru_pkg::DATA_W-1:0]  r_lsb, n_lsb;
    logic                         r_failed, n_failed;
    logic                         r_out_valid, n_out_valid;
    logic [sxru_pkg::DATA_W-1:0]  r_rom, n_rom;
    logic                         r_kind, n_kind;

    logic [PW-1:0]                p;
    logic [PW-1:0]                p_inc;
    logic [sxru_pkg::DATA_W-1:0]  b;
    logic [sxru_pkg::LEN_W-1:0]   len;
    logic                         failed_now;
    logic [14:0]                  counter;
    logic [1:0]                   off_m1;
    logic                         grp_ok;

    assign o_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_rom_byte = r_rom;
    assign o_result_kind = r_kind;

    always_comb begin
        b = i_item.data_byte;
        len = i_item.message_length;
        p = (i_item.first_of_message || i_item.first_of_dump) ? '0 : r_pos;
        p_inc = p + PW'(1);
        failed_now = i_item.first_of_dump ? 1'b0 : r_failed;
        counter = {r_cnt_hi, 7'b0} | {7'b0, b};
        off_m1 = r_off[1:0] - 2'd1;
        grp_ok = (CW'(r_start) + CW'(sxru_pkg::GROUP)) < CW'(len);

        n_pos = r_pos;
        n_off = r_off;
        n_start = r_start;
        n_acc = r_acc;
        n_cnt_hi = r_cnt_hi;
        n_expect = r_expect;
        n_lsb = r_lsb;
        n_failed = r_failed;
        n_out_valid = r_out_valid && i_out_stall;
        n_rom = r_rom;
        n_kind = r_kind;

        if (i_ctrl.advance) begin
            n_out_valid = 1'b0;
            n_failed = failed_now;
            n_expect = i_item.first_of_dump ? sxru_pkg::CNT_W'(1) : r_expect;

            // position and group tracking
            if (p < POS_MAX) begin
                n_pos = p_inc;
                if (p_inc == PW'(sxru_pkg::DATA_START)) begin
                    n_off = 3'd0;
                    n_start = p_inc;
                end else if (p_inc > PW'(sxru_pkg::DATA_START)) begin
                    if (r_off == 3'(sxru_pkg::GROUP - 1)) begin
                        n_off = 3'd0;
                        n_start = p_inc;
                    end else begin
                        n_off = r_off + 3'd1;
                    end
                end
            end else begin
                n_pos = POS_MAX;
            end

            if (!failed_now) begin
                priority if (p == PW'(0)) begin
                    n_acc = (len >= sxru_pkg::MIN_LEN);
                end else if (p == PW'(1)) begin
                    if (b != sxru_pkg::HDR_BYTE1) n_acc = 1'b0;
                end else if (p == PW'(3)) begin
                    if (b != sxru_pkg::HDR_BYTE3) n_acc = 1'b0;
                end else if (p == PW'(4)) begin
                    if (b != sxru_pkg::HDR_DUMP_A && b != sxru_pkg::HDR_DUMP_B &&
                        b != sxru_pkg::HDR_DUMP_C) n_acc = 1'b0;
                end else if (p == PW'(6)) begin
                    n_cnt_hi = b;
                end else if (p == PW'(7)) begin
                    if (r_acc && len >= sxru_pkg::MIN_LEN) begin
                        if (sxru_pkg::CNT_W'(counter) != n_expect && counter != 15'd1) begin
                            n_failed = 1'b1;
                            n_acc = 1'b0;
                            n_out_valid = 1'b1;
                            n_rom = '0;
                            n_kind = sxru_pkg::KIND_ERR;
                        end else begin
                            n_expect = sxru_pkg::CNT_W'(counter) + sxru_pkg::CNT_W'(1);
                        end
                    end else begin
                        n_acc = 1'b0;
                    end
                end else if (p >= PW'(sxru_pkg::DATA_START) && r_acc && grp_ok) begin
                    if (r_off == 3'd0) begin
                        n_lsb = b;
                    end else begin
                        n_out_valid = 1'b1;
                        n_rom = {b[6:0], r_lsb[off_m1]};
                        n_kind = sxru_pkg::KIND_ROM;
                    end
                end else begin
                    n_acc = r_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_off <= '0;
            r_start <= '0;
            r_acc <= 1'b0;
            r_cnt_hi <= '0;
            r_expect <= sxru_pkg::CNT_W'(1);
            r_lsb <= '0;
            r_failed <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_off <= n_off;
            r_start <= n_start;
            r_acc <= n_acc;
            r_cnt_hi <= n_cnt_hi;
            r_expect <= n_expect;
            r_lsb <= n_lsb;
            r_failed <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom <= n_rom;
        r_kind <= n_kind;
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == sxru_pkg::KIND_ERR) |-> (r_rom == '0))
        else $error("error result carries nonzero byte");

    a_err_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == sxru_pkg::KIND_ERR) |-> r_failed)
        else $error("error result without failed dump");

    a_pos_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte position beyond saturation");

    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off < 3'(sxru_pkg::GROUP))
        else $error("group offset out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_rom) && $stable(r_kind)))
        else $error("stalled result changed");
`endif

endmodule

### hdl/sysex_rom_dump_unpacker_core.sv
// Top level of the sysex ROM dump unpacker.
//
//  channel  direction  handshake                payload
//  in       input      i_in_valid / o_in_stall  i_data_byte, i_message_length,
//                                               i_first_of_message, i_first_of_dump
//  out      output     o_out_valid / i_out_stall o_rom_byte, o_result_kind
//
// One byte per cycle sustained while the output does not stall; a byte's result
// passes the input register, then the result register, around the unpack logic.
// Synchronous active-low reset clears position, header state, expected counter (to 1).
// A stalled result holds the result register; the input register still takes one byte.
module sysex_rom_dump_unpacker_core #(
    parameter int MAX_MESSAGE_LENGTH = sxru_pkg::MAX_MESSAGE_LENGTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [sxru_pkg::DATA_W-1:0] i_data_byte,
    input  logic [sxru_pkg::LEN_W-1:0]  i_message_length,
    input  logic                        i_first_of_message,
    input  logic                        i_first_of_dump,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sxru_pkg::DATA_W-1:0] o_rom_byte,
    output logic                        o_result_kind
);

    sxru_pkg::t_item    in_item;
    sxru_pkg::t_item    st_item;
    sxru_pkg::t_in_ctrl st_ctrl;
    logic               unpack_free;

    assign in_item.data_byte = i_data_byte;
    assign in_item.message_length = i_message_length;
    assign in_item.first_of_message = i_first_of_message;
    assign in_item.first_of_dump = i_first_of_dump;

    sxru_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (in_item),
        .i_advance  (unpack_free),
        .o_ctrl     (st_ctrl),
        .o_item     (st_item)
    );

    sxru_unpack #(
        .MAX_MESSAGE_LENGTH (MAX_MESSAGE_LENGTH)
    ) u_unpack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (st_ctrl),
        .i_item        (st_item),
        .o_free        (unpack_free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rom_byte    (o_rom_byte),
        .o_result_kind (o_result_kind)
    );

endmodule

### dv/tb_top.sv
// Self-checking testbench for the sysex ROM dump unpacker: table-driven and random byte streams.
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 160;
    localparam int TAIL_CYCLES = 20;

    localparam logic [7:0] B1 = sxru_pkg::HDR_BYTE1;
    localparam logic [7:0] B3 = sxru_pkg::HDR_BYTE3;
    localparam logic [7:0] DA = sxru_pkg::HDR_DUMP_A;
    localparam logic [7:0] DB = sxru_pkg::HDR_DUMP_B;
    localparam logic [7:0] DC = sxru_pkg::HDR_DUMP_C;

    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_ERR
    } t_chk;

    typedef struct packed {
        logic                       fod;
        logic                       fom;
        logic [sxru_pkg::LEN_W-1:0] len_head;
        logic [sxru_pkg::LEN_W-1:0] len_tail;
        logic [7:0]                 b1;
        logic [7:0]                 b3;
        logic [7:0]                 b4;
        logic [7:0]                 chi;
        logic [7:0]                 clo;
        logic [12:0]                nbytes;
        logic                       fill_rand;
        logic [7:0]                 fill;
        t_chk                       chk;
    } t_msg_row;

    typedef struct packed {
        logic [sxru_pkg::DATA_W-1:0] rom;
        logic                        kind;
    } t_unpacked;

    localparam int DIR_ROWS = 21;
    // fod fom len_head len_tail b1 b3 b4 cnt_hi cnt_lo bytes fill_rand fill check
    t_msg_row dir_tab [DIR_ROWS] = '{
        '{0, 0, 12'd252, 12'd252, B1, B3, DA, 8'h00, 8'h01, 13'd20, 1, 8'h00, CHK_PRED},
        '{0, 1, 12'd252, 12'd252, B1, B3, DB, 8'h00, 8'h02, 13'd15, 0, 8'hFF, CHK_PRED},
        '{0, 1, 12'd252, 12'd252, B1, B3, DC, 8'h00, 8'h03, 13'd15, 0, 8'h00, CHK_PRED},
        '{0, 1, 12'd251, 12'd251, B1, B3, DA, 8'h00, 8'h04, 13'd20, 1, 8'h00, CHK_NONE},
        '{0, 1, 12'd0,   12'd0,   B1, B3, DA, 8'h00, 8'h04, 13'd12, 1, 8'h00, CHK_NONE},
        '{0, 1, 12'd252, 12'd252, 8'h3F, B3, DA, 8'h00, 8'h04, 13'd20, 1, 8'h00, CHK_NONE},
        '{0, 1, 12'd252, 12'd252, B1, 8'h7E, DA, 8'h00, 8'h04, 13'd20, 1, 8'h00, CHK_NONE},
        '{0, 1, 12'd252, 12'd252, B1, B3, 8'h70, 8'h00, 8'h04, 13'd20, 1, 8'h00, CHK_NONE},
        '{0, 1, 12'd252, 12'd252, B1, B3, 8'h74, 8'h00, 8'h04, 13'd20, 1, 8'h00, CHK_NONE},
        '{0, 1, 12'd4095, 12'd4095, B1, B3, DB, 8'h00, 8'h01, 13'd30, 1, 8'h00, CHK_PRED},
        '{0, 1, 12'd300, 12'd100, B1, B3, DB, 8'h00, 8'h02, 13'd20, 1, 8'h00, CHK_NONE},
        '{0, 1, 12'd252, 12'd252, B1, B3, DB, 8'h01, 8'h05, 13'd20, 1, 8'h00, CHK_ERR},
        '{0, 1, 12'd252, 12'd252, B1, B3, DB, 8'h00, 8'h02, 13'd20, 1, 8'h00, CHK_NONE},
        '{1, 0, 12'd252, 12'd252, B1, B3, DA, 8'h00, 8'h01, 13'd30, 1, 8'h00, CHK_PRED},
        '{0, 1, 12'd252, 12'd252, B1, B3, DA, 8'h00, 8'h02, 13'd260, 1, 8'h00, CHK_PRED},
        '{0, 1, 12'd252, 12'd252, B1, B3, DA, 8'hFF, 8'hFF, 13'd20, 1, 8'h00, CHK_ERR},
        '{1, 1, 12'd252, 12'd252, B1, B3, DA, 8'h7F, 8'h7F, 13'd20, 1, 8'h00, CHK_ERR},
        '{1, 1, 12'd4095, 12'd4095, B1, B3, DC, 8'h00, 8'h01, 13'd40, 1, 8'h00, CHK_PRED},
        '{0, 1, 12'd252, 12'd252, B1, B3, DC, 8'h00, 8'h02, 13'd25, 0, 8'h55, CHK_PRED},
        '{0, 1, 12'd252, 12'd252, B1, B3, DC, 8'h00, 8'h04, 13'd8, 1, 8'h00, CHK_ERR},
        '{1, 1, 12'd252, 12'd252, B1, B3, DA, 8'h00, 8'h01, 13'd5, 1, 8'h00, CHK_PRED}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [sxru_pkg::DATA_W-1:0]   i_data_byte;
    logic [sxru_pkg::LEN_W-1:0]    i_message_length;
    logic                          i_first_of_message;
    logic                          i_first_of_dump;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [sxru_pkg::DATA_W-1:0]   o_rom_byte;
    logic                          o_result_kind;

    t_unpacked     pending_unpacked [$];
    int unsigned   cycles = 0;
    int            n_fail = 0;
    int            n_bytes = 0;
    int            n_rom = 0;
    int            n_err = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_reqs = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    // predictor state
    int unsigned   pos_q;
    logic          hdr_ok;
    logic [7:0]    cnt_hi;
    logic [15:0]   next_count;
    logic [7:0]    lsb_q;
    logic          dump_dead;

    sysex_rom_dump_unpacker_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_message_length   (i_message_length),
        .i_first_of_message (i_first_of_message),
        .i_first_of_dump    (i_first_of_dump),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_rom_byte         (o_rom_byte),
        .o_result_kind      (o_result_kind)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("sysex_rom_dump_unpacker_core: mismatch");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_unpacked want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_result_kind == sxru_pkg::KIND_ERR) n_err++;
            else n_rom++;
            if (pending_unpacked.size() == 0) begin
                $error("unexpected result: rom_byte %02h result_kind %0b",
                       o_rom_byte, o_result_kind);
                n_fail++;
            end else begin
                want = pending_unpacked.pop_front();
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0b, got %0b", want.kind, o_result_kind);
                    n_fail++;
                end
                if (o_rom_byte !== want.rom) begin
                    $error("rom_byte: expected %02h, got %02h", want.rom, o_rom_byte);
                    n_fail++;
                end
            end
        end
    end

    function automatic void queue_result(input t_unpacked r);
        pending_unpacked = {pending_unpacked, r};
    endfunction

    function automatic void clear_unpacker();
        pos_q = 0;
        hdr_ok = 1'b0;
        cnt_hi = 8'h00;
        next_count = 16'd1;
        lsb_q = 8'h00;
        dump_dead = 1'b0;
    endfunction

    function automatic void unpack_step(input logic [7:0] b,
                                        input logic [sxru_pkg::LEN_W-1:0] len,
                                        input logic fom, input logic fod,
                                        output bit got, output t_unpacked res);
        int unsigned p;
        int unsigned off;
        int unsigned grp_start;
        int unsigned cnt;
        got = 1'b0;
        res = '{rom: 8'h00, kind: sxru_pkg::KIND_ROM};
        if (fod) begin
            next_count = 16'd1;
            dump_dead = 1'b0;
        end
        p = (fom || fod) ? 0 : pos_q;
        pos_q = (p < sxru_pkg::MAX_MESSAGE_LENGTH_DEF) ? p + 1 :
                sxru_pkg::MAX_MESSAGE_LENGTH_DEF;
        if (dump_dead) return;
        if (p == 0) begin
            hdr_ok = (len >= sxru_pkg::MIN_LEN);
        end else if (p == 1) begin
            if (b != sxru_pkg::HDR_BYTE1) hdr_ok = 1'b0;
        end else if (p == 3) begin
            if (b != sxru_pkg::HDR_BYTE3) hdr_ok = 1'b0;
        end else if (p == 4) begin
            if (b != sxru_pkg::HDR_DUMP_A && b != sxru_pkg::HDR_DUMP_B &&
                b != sxru_pkg::HDR_DUMP_C) hdr_ok = 1'b0;
        end else if (p == 6) begin
            cnt_hi = b;
        end else if (p == 7) begin
            if (len < sxru_pkg::MIN_LEN) hdr_ok = 1'b0;
            if (hdr_ok) begin
                cnt = (32'(cnt_hi) << 7) | 32'(b);
                if (cnt != 32'(next_count) && cnt != 1) begin
                    dump_dead = 1'b1;
                    hdr_ok = 1'b0;
                    got = 1'b1;
                    res.kind = sxru_pkg::KIND_ERR;
                end else begin
                    next_count = 16'(cnt + 1);
                end
            end
        end else if (p >= sxru_pkg::DATA_START && hdr_ok) begin
            off = (p - sxru_pkg::DATA_START) % sxru_pkg::GROUP;
            grp_start = p - off;
            if (grp_start + sxru_pkg::GROUP < 32'(len)) begin
                if (off == 0) begin
                    lsb_q = b;
                end else begin
                    got = 1'b1;
                    res.rom = {b[6:0], lsb_q[off-1]};
                end
            end
        end
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic drive_byte(input logic [7:0] b, input logic [sxru_pkg::LEN_W-1:0] len,
                              input logic fom, input logic fod, input t_chk chk);
        int gap;
        bit got;
        t_unpacked res;
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_message_length <= len;
        i_first_of_message <= fom;
        i_first_of_dump <= fod;
        do @(posedge i_clk); while (o_in_stall);
        n_bytes++;
        unpack_step(b, len, fom, fod, got, res);
        if (chk == CHK_PRED && got) queue_result(res);
        else if (chk == CHK_ERR) queue_result('{rom: 8'h00, kind: sxru_pkg::KIND_ERR});
        @(negedge i_clk);
    endtask

    task automatic send_message(input t_msg_row m);
        logic [7:0] b;
        logic [sxru_pkg::LEN_W-1:0] len;
        t_chk c;
        int i;
        for (i = 0; i < int'(m.nbytes); i++) begin
            case (i)
                0: b = 8'hF0;
                1: b = m.b1;
                3: b = m.b3;
                4: b = m.b4;
                6: b = m.chi;
                7: b = m.clo;
                2, 5: b = 8'($urandom);
                default: b = m.fill_rand ? 8'($urandom) : m.fill;
            endcase
            len = (i < 7) ? m.len_head : m.len_tail;
            c = (m.chk == CHK_ERR && i != 7) ? CHK_NONE : m.chk;
            drive_byte(b, len, (i == 0) && m.fom, (i == 0) && m.fod, c);
        end
    endtask

    task automatic rand_message();
        t_msg_row m;
        int r;
        int n;
        int i;
        int unsigned c;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                drive_byte(8'($urandom), 12'($urandom), $urandom_range(0, 4) == 0,
                           $urandom_range(0, 9) == 0, CHK_PRED);
            return;
        end
        m.fod = dump_dead ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) < 12);
        m.fom = m.fod ? 1'($urandom) : 1'b1;
        r = $urandom_range(0, 99);
        if (r < 70) m.len_head = 12'($urandom_range(252, 300));
        else if (r < 85) m.len_head = 12'($urandom_range(301, 4095));
        else m.len_head = 12'($urandom_range(0, 251));
        m.len_tail = ($urandom_range(0, 99) < 95) ? m.len_head : 12'($urandom);
        m.b1 = ($urandom_range(0, 99) < 92) ? sxru_pkg::HDR_BYTE1 : 8'($urandom);
        m.b3 = ($urandom_range(0, 99) < 92) ? sxru_pkg::HDR_BYTE3 : 8'($urandom);
        case ($urandom_range(0, 12))
            0, 1, 2, 3: m.b4 = sxru_pkg::HDR_DUMP_A;
            4, 5, 6, 7: m.b4 = sxru_pkg::HDR_DUMP_B;
            8, 9, 10, 11: m.b4 = sxru_pkg::HDR_DUMP_C;
            default: m.b4 = 8'($urandom);
        endcase
        c = m.fod ? 1 : 32'(next_count);
        r = $urandom_range(0, 99);
        if (r < 80) begin
            m.chi = 8'(c >> 7);
            m.clo = 8'(c & 32'h7F);
        end else if (r < 88) begin
            m.chi = 8'h00;
            m.clo = 8'h01;
        end else begin
            m.chi = 8'($urandom);
            m.clo = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 85) m.nbytes = 13'($urandom_range(8, 60));
        else if (r < 95) m.nbytes = 13'($urandom_range(1, 7));
        else m.nbytes = 13'($urandom_range(240, 320));
        m.fill_rand = ($urandom_range(0, 9) != 0);
        m.fill = 8'($urandom);
        m.chk = CHK_PRED;
        send_message(m);
    endtask

    initial begin
        int i;
        int ph;
        int goal;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_message_length = '0;
        i_first_of_message = 1'b0;
        i_first_of_dump = 1'b0;
        clear_unpacker();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) send_message(dir_tab[i]);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (ph == 0) hold_reqs++;
            goal = n_bytes + PHASE_BYTES;
            while (n_bytes < goal) rand_message();
        end
        i_in_valid <= 1'b0;

        while (pending_unpacked.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d byte transfers, %0d ROM bytes and %0d sequence errors,",
                 n_bytes, n_rom, n_err);
        $display("over directed dumps and four flow-control phases with one long output hold");
        if (n_fail == 0) $display("sysex_rom_dump_unpacker_core: match");
        else $display("sysex_rom_dump_unpacker_core: mismatch");
        $finish;
    end

endmodule
